// ===== sv/rbs_pkg.sv =====
package rbs_pkg;

   localparam int DEF_ACTIVE_SLOTS = 8;
   localparam int DEF_TOTAL_SLOTS  = 32;
   localparam int DEF_TAG_BITS     = 16;

   localparam logic [1:0] CMD_SUBMIT = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;
   localparam logic [1:0] CMD_NEXT   = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_INVALID    = 3'd1;
   localparam logic [2:0] ST_DUPLICATE  = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_NOT_ACTIVE = 3'd4;
   localparam logic [2:0] ST_UNKNOWN    = 3'd5;

   localparam logic [1:0] RSN_EOS    = 2'd0;
   localparam logic [1:0] RSN_BUDGET = 2'd1;
   localparam logic [1:0] RSN_CANCEL = 2'd2;

   localparam logic [1:0] REG_MAX_ACTIVE = 2'd0;
   localparam logic [1:0] REG_MAX_TOTAL  = 2'd1;
   localparam logic [1:0] REG_EOS_TOKEN  = 2'd2;

   localparam logic [3:0]  RST_MAX_ACTIVE = 4'd8;
   localparam logic [5:0]  RST_MAX_TOTAL  = 6'd32;
   localparam logic [31:0] RST_EOS_TOKEN  = 32'd0;

   typedef struct packed {
      logic [1:0]         command;
      logic [15:0]        request_tag;
      logic [15:0]        prompt_length;
      logic [15:0]        token_budget;
      logic signed [31:0] token_value;
      logic [3:0]         batch_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        finished;
      logic [15:0] finished_tag;
      logic [1:0]  end_cause;
      logic        admitted;
      logic [15:0] admitted_tag;
      logic        batch_valid;
      logic [15:0] batch_tag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic remove_en;
      logic load_en;
      logic incr_en;
   } act_ctl_type;

   typedef struct packed {
      logic remove_en;
      logic shift_all;
      logic push_en;
   } wait_ctl_type;

endpackage

// ===== sv/request_batch_scheduler_core.sv =====
// channel   direction  handshake               payload
// req_      in         req_valid / req_stall   req_data (req_type)
// rsp_      out        rsp_valid / rsp_stall   rsp_data (rsp_type)
// csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// one request at a time: accept, tag search, output register load, then the results
// one by one, each held while rsp_stall is high; submit, completion and next batch
// first run the admission state, which moves waiting requests one at a time into the
// active row by the single admission path until no more can be admitted
// reset clears counts, control and registers; tables are not cleared
// req_stall is high from accept until the last result transfer completes
module request_batch_scheduler_core import rbs_pkg::*; #(
   parameter int ACTIVE_SLOTS = DEF_ACTIVE_SLOTS,
   parameter int TOTAL_SLOTS  = DEF_TOTAL_SLOTS,
   parameter int TAG_BITS     = DEF_TAG_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int AC_W = $clog2(ACTIVE_SLOTS + 1);
   localparam int WC_W = $clog2(TOTAL_SLOTS + 1);
   localparam logic [31:0] TAG_MASK = 32'((64'd1 << TAG_BITS) - 64'd1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_ADMIT = 3'd2;
   localparam logic [2:0] S_OUT   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [3:0]          max_active_ff;
   logic [5:0]          max_total_ff;
   logic [31:0]         eos_ff;
   logic [AC_W-1:0]     ac_ff, ac_in;
   logic [WC_W-1:0]     wc_ff, wc_in;
   logic [AC_W-1:0]     nadm_ff, nadm_in;
   logic [AC_W-1:0]     nb_ff, nb_in;
   logic [AC_W-1:0]     k_ff, k_in;
   logic [1:0]          cmd_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [15:0]         plen_ff, bud_ff;
   logic [31:0]         tok_ff;
   logic [3:0]          blim_ff;
   logic [2:0]          status_ff, status_in;
   logic                fin_ff, fin_in;
   logic [1:0]          reason_ff, reason_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;
   logic                rsp_load, adm_wr, bat_load;
   logic [AC_W-1:0]     k_sel, n_val;
   rsp_type             rsp_next;

   act_ctl_type         act_ctl;
   wait_ctl_type        wait_ctl;
   logic [TAG_BITS-1:0] tag_in;

   logic [ACTIVE_SLOTS-1:0] act_match, act_rm;
   logic [TAG_BITS-1:0]     act_tag [ACTIVE_SLOTS];
   logic [15:0]             act_gen [ACTIVE_SLOTS];
   logic [15:0]             act_bud [ACTIVE_SLOTS];
   logic [TOTAL_SLOTS-1:0]  wait_match, wait_rm;
   logic [TAG_BITS-1:0]     wait_tag [TOTAL_SLOTS];
   logic [15:0]             wait_bud [TOTAL_SLOTS];

   logic [TAG_BITS-1:0]     adm_ff [ACTIVE_SLOTS];
   logic [TAG_BITS-1:0]     bat_ff [ACTIVE_SLOTS];

   logic                act_any, wait_any;
   logic [15:0]         sel_gen, sel_bud, gen_inc;
   logic [5:0]          act_lim6;
   logic                admit_ok, full;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
   assign tag_in    = TAG_BITS'(32'(req_data.request_tag) & TAG_MASK);

   genvar gi;
   generate
      for (gi = 0; gi < ACTIVE_SLOTS; gi++) begin : g_act
         logic                rin;
         logic [TAG_BITS-1:0] ntag;
         logic [15:0]         ngen, nbud;
         if (gi == 0) begin : g_first
            assign rin = 1'b0;
         end else begin : g_mid
            assign rin = act_rm[gi-1];
         end
         if (gi == ACTIVE_SLOTS - 1) begin : g_end
            assign ntag = '0;
            assign ngen = '0;
            assign nbud = '0;
         end else begin : g_nxt
            assign ntag = act_tag[gi+1];
            assign ngen = act_gen[gi+1];
            assign nbud = act_bud[gi+1];
         end
         rbs_act_cell #(.TAG_BITS(TAG_BITS), .CNT_W(AC_W), .IDX(gi)) u_cell (
            .clock       (clock),
            .ctl         (act_ctl),
            .count       (ac_ff),
            .search_tag  (tag_ff),
            .load_tag    (wait_tag[0]),
            .load_budget (wait_bud[0]),
            .rm_in       (rin),
            .nxt_tag     (ntag),
            .nxt_gen     (ngen),
            .nxt_budget  (nbud),
            .match       (act_match[gi]),
            .rm_out      (act_rm[gi]),
            .tag         (act_tag[gi]),
            .gen         (act_gen[gi]),
            .budget      (act_bud[gi])
         );
      end
      for (gi = 0; gi < TOTAL_SLOTS; gi++) begin : g_wait
         logic                rin;
         logic [TAG_BITS-1:0] ntag;
         logic [15:0]         nbud;
         if (gi == 0) begin : g_first
            assign rin = wait_ctl.shift_all;
         end else begin : g_mid
            assign rin = wait_rm[gi-1];
         end
         if (gi == TOTAL_SLOTS - 1) begin : g_end
            assign ntag = '0;
            assign nbud = '0;
         end else begin : g_nxt
            assign ntag = wait_tag[gi+1];
            assign nbud = wait_bud[gi+1];
         end
         rbs_wait_cell #(.TAG_BITS(TAG_BITS), .CNT_W(WC_W), .IDX(gi)) u_cell (
            .clock       (clock),
            .ctl         (wait_ctl),
            .count       (wc_ff),
            .search_tag  (tag_ff),
            .push_tag    (tag_ff),
            .push_budget (bud_ff),
            .rm_in       (rin),
            .nxt_tag     (ntag),
            .nxt_budget  (nbud),
            .match       (wait_match[gi]),
            .rm_out      (wait_rm[gi]),
            .tag         (wait_tag[gi]),
            .budget      (wait_bud[gi])
         );
      end
   endgenerate

   always_comb begin
      sel_gen = '0;
      sel_bud = '0;
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
         sel_gen = sel_gen | (act_match[i] ? act_gen[i] : 16'd0);
         sel_bud = sel_bud | (act_match[i] ? act_bud[i] : 16'd0);
      end
   end

   assign act_any  = |act_match;
   assign wait_any = |wait_match;
   assign gen_inc  = sel_gen + 16'd1;
   assign act_lim6 = ({2'b00, max_active_ff} < max_total_ff) ? {2'b00, max_active_ff}
                                                              : max_total_ff;
   assign admit_ok = (32'(ac_ff) < 32'(act_lim6)) && (32'(ac_ff) < ACTIVE_SLOTS)
                     && (wc_ff != '0);
   assign full = ((32'(ac_ff) + 32'(wc_ff)) >=
                  ((32'(max_total_ff) > TOTAL_SLOTS) ? TOTAL_SLOTS : 32'(max_total_ff)))
                 || (32'(wc_ff) >= TOTAL_SLOTS);

   assign k_sel = (state_ff == S_OUT) ? '0 : k_ff;
   always_comb begin
      n_val = AC_W'(1);
      if (nadm_ff > n_val) n_val = nadm_ff;
      if (nb_ff > n_val) n_val = nb_ff;
   end

   always_comb begin
      rsp_next               = '0;
      rsp_next.status        = status_ff;
      rsp_next.finished      = (k_sel == '0) && fin_ff;
      rsp_next.finished_tag  = ((k_sel == '0) && fin_ff) ? 16'(tag_ff) : 16'd0;
      rsp_next.end_cause     = ((k_sel == '0) && fin_ff) ? reason_ff : 2'd0;
      rsp_next.admitted      = k_sel < nadm_ff;
      rsp_next.admitted_tag  = (k_sel < nadm_ff) ? 16'(adm_ff[0]) : 16'd0;
      rsp_next.batch_valid   = k_sel < nb_ff;
      rsp_next.batch_tag     = (k_sel < nb_ff) ? 16'(bat_ff[0]) : 16'd0;
      rsp_next.last          = (k_sel + AC_W'(1)) == n_val;
   end

   always_comb begin
      state_in     = state_ff;
      ac_in        = ac_ff;
      wc_in        = wc_ff;
      nadm_in      = nadm_ff;
      nb_in        = nb_ff;
      k_in         = k_ff;
      status_in    = status_ff;
      fin_in       = fin_ff;
      reason_in    = reason_ff;
      rsp_valid_in = rsp_valid_ff;
      act_ctl      = '0;
      wait_ctl     = '0;
      rsp_load     = 1'b0;
      adm_wr       = 1'b0;
      bat_load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_OK;
               fin_in    = 1'b0;
               reason_in = RSN_EOS;
               nadm_in   = '0;
               nb_in     = '0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_OUT;
            unique case (cmd_ff)
               CMD_SUBMIT: begin
                  if (tag_ff == '0 || plen_ff == 16'd0 || bud_ff == 16'd0) begin
                     status_in = ST_INVALID;
                  end else if (act_any || wait_any) begin
                     status_in = ST_DUPLICATE;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     wait_ctl.push_en = 1'b1;
                     wc_in            = wc_ff + WC_W'(1);
                     state_in         = S_ADMIT;
                  end
               end
               CMD_APPEND: begin
                  if (!act_any) begin
                     status_in = ST_NOT_ACTIVE;
                  end else if (tok_ff == eos_ff || gen_inc >= sel_bud) begin
                     act_ctl.remove_en = 1'b1;
                     fin_in            = 1'b1;
                     reason_in         = (tok_ff == eos_ff) ? RSN_EOS : RSN_BUDGET;
                     ac_in             = ac_ff - AC_W'(1);
                     state_in          = S_ADMIT;
                  end else begin
                     act_ctl.incr_en = 1'b1;
                  end
               end
               CMD_CANCEL: begin
                  if (act_any) begin
                     act_ctl.remove_en = 1'b1;
                     fin_in            = 1'b1;
                     reason_in         = RSN_CANCEL;
                     ac_in             = ac_ff - AC_W'(1);
                     state_in          = S_ADMIT;
                  end else if (wait_any) begin
                     wait_ctl.remove_en = 1'b1;
                     fin_in             = 1'b1;
                     reason_in          = RSN_CANCEL;
                     wc_in              = wc_ff - WC_W'(1);
                  end else begin
                     status_in = ST_UNKNOWN;
                  end
               end
               default: begin
                  state_in = S_ADMIT;
               end
            endcase
         end
         S_ADMIT: begin
            if (admit_ok) begin
               act_ctl.load_en    = 1'b1;
               wait_ctl.shift_all = 1'b1;
               adm_wr             = 1'b1;
               nadm_in            = nadm_ff + AC_W'(1);
               ac_in              = ac_ff + AC_W'(1);
               wc_in              = wc_ff - WC_W'(1);
            end else begin
               state_in = S_OUT;
               if (cmd_ff == CMD_NEXT) begin
                  bat_load = 1'b1;
                  nb_in    = (blim_ff != 4'd0 && 32'(blim_ff) < 32'(ac_ff)) ?
                             AC_W'(blim_ff) : ac_ff;
               end
            end
         end
         S_OUT: begin
            rsp_load     = 1'b1;
            rsp_valid_in = 1'b1;
            k_in         = AC_W'(1);
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (k_ff == n_val) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  rsp_load = 1'b1;
                  k_in     = k_ff + AC_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ac_ff         <= '0;
         wc_ff         <= '0;
         nadm_ff       <= '0;
         nb_ff         <= '0;
         k_ff          <= '0;
         status_ff     <= ST_OK;
         fin_ff        <= 1'b0;
         reason_ff     <= RSN_EOS;
         rsp_valid_ff  <= 1'b0;
         max_active_ff <= RST_MAX_ACTIVE;
         max_total_ff  <= RST_MAX_TOTAL;
         eos_ff        <= RST_EOS_TOKEN;
      end else begin
         state_ff     <= state_in;
         ac_ff        <= ac_in;
         wc_ff        <= wc_in;
         nadm_ff      <= nadm_in;
         nb_ff        <= nb_in;
         k_ff         <= k_in;
         status_ff    <= status_in;
         fin_ff       <= fin_in;
         reason_ff    <= reason_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_MAX_ACTIVE: max_active_ff <= csr_data[3:0];
               REG_MAX_TOTAL:  max_total_ff  <= csr_data[5:0];
               REG_EOS_TOKEN:  eos_ff        <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // request payload and result chains
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff  <= req_data.command;
         tag_ff  <= tag_in;
         plen_ff <= req_data.prompt_length;
         bud_ff  <= req_data.token_budget;
         tok_ff  <= req_data.token_value;
         blim_ff <= req_data.batch_limit;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
         if (adm_wr && (nadm_ff == AC_W'(i))) begin
            adm_ff[i] <= wait_tag[0];
         end else if (rsp_load) begin
            adm_ff[i] <= (i == ACTIVE_SLOTS - 1) ? '0 : adm_ff[(i + 1) % ACTIVE_SLOTS];
         end
         if (bat_load) begin
            bat_ff[i] <= act_tag[i];
         end else if (rsp_load) begin
            bat_ff[i] <= (i == ACTIVE_SLOTS - 1) ? '0 : bat_ff[(i + 1) % ACTIVE_SLOTS];
         end
      end
   end

endmodule

// ===== sv/rbs_act_cell.sv =====
module rbs_act_cell import rbs_pkg::*; #(
   parameter int TAG_BITS = DEF_TAG_BITS,
   parameter int CNT_W    = 4,
   parameter int IDX      = 0
) (
   input  logic                clock,
   input  act_ctl_type         ctl,
   input  logic [CNT_W-1:0]    count,
   input  logic [TAG_BITS-1:0] search_tag,
   input  logic [TAG_BITS-1:0] load_tag,
   input  logic [15:0]         load_budget,
   input  logic                rm_in,
   input  logic [TAG_BITS-1:0] nxt_tag,
   input  logic [15:0]         nxt_gen,
   input  logic [15:0]         nxt_budget,
   output logic                match,
   output logic                rm_out,
   output logic [TAG_BITS-1:0] tag,
   output logic [15:0]         gen,
   output logic [15:0]         budget
);

   logic [TAG_BITS-1:0] tag_ff;
   logic [15:0]         gen_ff;
   logic [15:0]         budget_ff;
   logic                occupied;

   assign occupied = CNT_W'(IDX) < count;
   assign match    = occupied && (tag_ff == search_tag);
   assign rm_out   = rm_in | match;
   assign tag      = tag_ff;
   assign gen      = gen_ff;
   assign budget   = budget_ff;

   always_ff @(posedge clock) begin
      if (ctl.remove_en && rm_out) begin
         tag_ff    <= nxt_tag;
         gen_ff    <= nxt_gen;
         budget_ff <= nxt_budget;
      end else if (ctl.load_en && (CNT_W'(IDX) == count)) begin
         tag_ff    <= load_tag;
         gen_ff    <= 16'd0;
         budget_ff <= load_budget;
      end else if (ctl.incr_en && match) begin
         gen_ff <= gen_ff + 16'd1;
      end
   end

endmodule

// ===== sv/rbs_wait_cell.sv =====
module rbs_wait_cell import rbs_pkg::*; #(
   parameter int TAG_BITS = DEF_TAG_BITS,
   parameter int CNT_W    = 6,
   parameter int IDX      = 0
) (
   input  logic                clock,
   input  wait_ctl_type        ctl,
   input  logic [CNT_W-1:0]    count,
   input  logic [TAG_BITS-1:0] search_tag,
   input  logic [TAG_BITS-1:0] push_tag,
   input  logic [15:0]         push_budget,
   input  logic                rm_in,
   input  logic [TAG_BITS-1:0] nxt_tag,
   input  logic [15:0]         nxt_budget,
   output logic                match,
   output logic                rm_out,
   output logic [TAG_BITS-1:0] tag,
   output logic [15:0]         budget
);

   logic [TAG_BITS-1:0] tag_ff;
   logic [15:0]         budget_ff;
   logic                occupied;

   assign occupied = CNT_W'(IDX) < count;
   assign match    = occupied && (tag_ff == search_tag);
   assign rm_out   = rm_in | match;
   assign tag      = tag_ff;
   assign budget   = budget_ff;

   always_ff @(posedge clock) begin
      if ((ctl.remove_en || ctl.shift_all) && rm_out) begin
         tag_ff    <= nxt_tag;
         budget_ff <= nxt_budget;
      end else if (ctl.push_en && (CNT_W'(IDX) == count)) begin
         tag_ff    <= push_tag;
         budget_ff <= push_budget;
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import rbs_pkg::*;

   localparam int ACT_SLOTS = 8;
   localparam int TOT_SLOTS = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   request_batch_scheduler_core i_dut (.*);

   always #1 clock = ~clock;

   // scheduler shadow state
   logic [3:0]  sh_max_active;
   logic [5:0]  sh_max_total;
   logic [31:0] sh_eos;
   logic [15:0] act_tag [ACT_SLOTS];
   logic [15:0] act_gen [ACT_SLOTS];
   logic [15:0] act_bud [ACT_SLOTS];
   int          act_cnt;
   logic [15:0] wait_tag [TOT_SLOTS];
   logic [15:0] wait_bud [TOT_SLOTS];
   int          wait_cnt;

   rsp_type     step_rsp [ACT_SLOTS];
   int          step_adm;

   req_type     pending_reqs [$];
   rsp_type     expected_rsps [$];
   int          sender_idle_pct = 0;
   int          stall_pct = 0;
   bit          failed = 0;
   int          quiet_cycles = 0;

   function automatic void queue_req(req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic int active_limit();
      int m;
      m = (sh_max_active < sh_max_total) ? int'(sh_max_active) : int'(sh_max_total);
      return (m > ACT_SLOTS) ? ACT_SLOTS : m;
   endfunction

   function automatic void admit_waiting();
      int lim;
      lim = active_limit();
      while (act_cnt < lim && wait_cnt > 0) begin
         act_tag[act_cnt] = wait_tag[0];
         act_bud[act_cnt] = wait_bud[0];
         act_gen[act_cnt] = '0;
         act_cnt++;
         if (step_adm < ACT_SLOTS) begin
            step_rsp[step_adm].admitted = 1'b1;
            step_rsp[step_adm].admitted_tag = wait_tag[0];
            step_adm++;
         end
         for (int i = 0; i < wait_cnt - 1; i++) begin
            wait_tag[i] = wait_tag[i + 1];
            wait_bud[i] = wait_bud[i + 1];
         end
         wait_cnt--;
      end
   endfunction

   function automatic int find_active(logic [15:0] t);
      for (int i = 0; i < act_cnt; i++)
         if (act_tag[i] == t) return i;
      return -1;
   endfunction

   function automatic void retire_active(int idx, logic [1:0] why);
      step_rsp[0].finished = 1'b1;
      step_rsp[0].finished_tag = act_tag[idx];
      step_rsp[0].end_cause = why;
      for (int i = idx; i < act_cnt - 1; i++) begin
         act_tag[i] = act_tag[i + 1];
         act_gen[i] = act_gen[i + 1];
         act_bud[i] = act_bud[i + 1];
      end
      act_cnt--;
      admit_waiting();
   endfunction

   function automatic void schedule_request(req_type r);
      logic [2:0] st;
      int nb, n, idx, tot;
      bit dup, found;
      st = ST_OK;
      nb = 0;
      step_adm = 0;
      for (int k = 0; k < ACT_SLOTS; k++) step_rsp[k] = '0;
      case (r.command)
         CMD_SUBMIT: begin
            dup = find_active(r.request_tag) >= 0;
            for (int i = 0; i < wait_cnt; i++)
               if (wait_tag[i] == r.request_tag) dup = 1;
            tot = (sh_max_total > TOT_SLOTS) ? TOT_SLOTS : int'(sh_max_total);
            if (r.request_tag == 0 || r.prompt_length == 0 || r.token_budget == 0)
               st = ST_INVALID;
            else if (dup) st = ST_DUPLICATE;
            else if (act_cnt + wait_cnt >= tot || wait_cnt >= TOT_SLOTS) st = ST_FULL;
            else begin
               wait_tag[wait_cnt] = r.request_tag;
               wait_bud[wait_cnt] = r.token_budget;
               wait_cnt++;
               admit_waiting();
            end
         end
         CMD_APPEND: begin
            idx = find_active(r.request_tag);
            if (idx < 0) st = ST_NOT_ACTIVE;
            else begin
               act_gen[idx] = act_gen[idx] + 16'd1;
               if (r.token_value == sh_eos) retire_active(idx, RSN_EOS);
               else if (act_gen[idx] >= act_bud[idx]) retire_active(idx, RSN_BUDGET);
            end
         end
         CMD_CANCEL: begin
            idx = find_active(r.request_tag);
            if (idx >= 0) retire_active(idx, RSN_CANCEL);
            else begin
               found = 0;
               for (int i = 0; i < wait_cnt && !found; i++) begin
                  if (wait_tag[i] == r.request_tag) begin
                     step_rsp[0].finished = 1'b1;
                     step_rsp[0].finished_tag = r.request_tag;
                     step_rsp[0].end_cause = RSN_CANCEL;
                     for (int j = i; j < wait_cnt - 1; j++) begin
                        wait_tag[j] = wait_tag[j + 1];
                        wait_bud[j] = wait_bud[j + 1];
                     end
                     wait_cnt--;
                     found = 1;
                  end
               end
               if (!found) st = ST_UNKNOWN;
            end
         end
         default: begin
            admit_waiting();
            nb = act_cnt;
            if (r.batch_limit != 0 && int'(r.batch_limit) < nb) nb = int'(r.batch_limit);
            for (int i = 0; i < nb; i++) begin
               step_rsp[i].batch_valid = 1'b1;
               step_rsp[i].batch_tag = act_tag[i];
            end
         end
      endcase
      n = 1;
      if (step_adm > n) n = step_adm;
      if (nb > n) n = nb;
      for (int k = 0; k < n; k++) begin
         step_rsp[k].status = st;
         step_rsp[k].last = (k == n - 1);
         expected_rsps.insert(expected_rsps.size(), step_rsp[k]);
      end
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pending_reqs[0];
               pending_reqs.delete(0);
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid && pending_reqs.size() > 0
                      && $urandom_range(99) >= sender_idle_pct) begin
            req_data <= pending_reqs[0];
            pending_reqs.delete(0);
            req_valid <= 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_valid && !req_stall) begin
            schedule_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transfer %p", rsp_data);
               failed = 1;
            end else begin
               want = expected_rsps[0];
               expected_rsps.delete(0);
               if (rsp_data.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, rsp_data.status); failed = 1; end
               if (rsp_data.finished !== want.finished) begin
                  $error("finished exp %0d got %0d", want.finished, rsp_data.finished); failed = 1; end
               if (rsp_data.finished_tag !== want.finished_tag) begin
                  $error("finished_tag exp %0h got %0h", want.finished_tag,
                         rsp_data.finished_tag); failed = 1; end
               if (rsp_data.end_cause !== want.end_cause) begin
                  $error("end_cause exp %0d got %0d", want.end_cause,
                         rsp_data.end_cause); failed = 1; end
               if (rsp_data.admitted !== want.admitted) begin
                  $error("admitted exp %0d got %0d", want.admitted, rsp_data.admitted); failed = 1; end
               if (rsp_data.admitted_tag !== want.admitted_tag) begin
                  $error("admitted_tag exp %0h got %0h", want.admitted_tag,
                         rsp_data.admitted_tag); failed = 1; end
               if (rsp_data.batch_valid !== want.batch_valid) begin
                  $error("batch_valid exp %0d got %0d", want.batch_valid,
                         rsp_data.batch_valid); failed = 1; end
               if (rsp_data.batch_tag !== want.batch_tag) begin
                  $error("batch_tag exp %0h got %0h", want.batch_tag, rsp_data.batch_tag); failed = 1; end
               if (rsp_data.last !== want.last) begin
                  $error("last exp %0d got %0d", want.last, rsp_data.last); failed = 1; end
            end
         end
         if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MAX_ACTIVE: sh_max_active = val[3:0];
         REG_MAX_TOTAL:  sh_max_total = val[5:0];
         default:        sh_eos = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_req(logic [1:0] c, logic [15:0] t, logic [15:0] p,
                                        logic [15:0] b, logic [31:0] v, logic [3:0] l);
      req_type r;
      r.command = c; r.request_tag = t; r.prompt_length = p;
      r.token_budget = b; r.token_value = v; r.batch_limit = l;
      return r;
   endfunction

   // mostly tags from a small pool so commands hit live requests
   function automatic req_type random_req();
      logic [15:0] t;
      int pick;
      t = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
      if ($urandom_range(19) == 0) t = '0;
      pick = $urandom_range(99);
      if (pick < 35)
         return make_req(CMD_SUBMIT, t,
                         ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom),
                         ($urandom_range(15) == 0) ? 16'd0 :
                         (($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4))),
                         $urandom, 4'($urandom));
      else if (pick < 70)
         return make_req(CMD_APPEND, t, 16'($urandom), 16'($urandom),
                         ($urandom_range(5) == 0) ? sh_eos : $urandom, 4'($urandom));
      else if (pick < 82)
         return make_req(CMD_CANCEL, t, 16'($urandom), 16'($urandom), $urandom, 4'($urandom));
      else
         return make_req(CMD_NEXT, t, 16'($urandom), 16'($urandom), $urandom,
                         4'($urandom_range(0, 8)));
   endfunction

   initial begin
      sh_max_active = RST_MAX_ACTIVE;
      sh_max_total = RST_MAX_TOTAL;
      sh_eos = RST_EOS_TOKEN;
      act_cnt = 0;
      wait_cnt = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, every command, check order and corner cases
      write_csr(REG_EOS_TOKEN, 32'h8000_0000);
      queue_req(make_req(CMD_SUBMIT, 16'd0, 16'd5, 16'd5, 0, 0));
      queue_req(make_req(CMD_SUBMIT, 16'd1, 16'd0, 16'd5, 0, 0));
      queue_req(make_req(CMD_SUBMIT, 16'd1, 16'd5, 16'd0, 0, 0));
      queue_req(make_req(CMD_SUBMIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF));
      queue_req(make_req(CMD_SUBMIT, 16'hFFFF, 16'd1, 16'd1, 0, 0));
      queue_req(make_req(CMD_SUBMIT, 16'd2, 16'd1, 16'd1, 0, 0));
      queue_req(make_req(CMD_SUBMIT, 16'd3, 16'd1, 16'd2, 0, 0));
      queue_req(make_req(CMD_APPEND, 16'd0, 0, 0, 0, 0));
      queue_req(make_req(CMD_CANCEL, 16'd0, 0, 0, 0, 0));
      queue_req(make_req(CMD_APPEND, 16'd2, 0, 0, 32'h7FFF_FFFF, 0));
      queue_req(make_req(CMD_APPEND, 16'd3, 0, 0, 32'h8000_0000, 0));
      queue_req(make_req(CMD_APPEND, 16'hFFFF, 0, 0, 32'h1234_5678, 0));
      queue_req(make_req(CMD_NEXT, 16'd0, 0, 0, 0, 4'd0));
      queue_req(make_req(CMD_NEXT, 16'd0, 0, 0, 0, 4'd8));
      queue_req(make_req(CMD_CANCEL, 16'hFFFF, 0, 0, 0, 0));
      queue_req(make_req(CMD_CANCEL, 16'd77, 0, 0, 0, 0));
      wait_drained();
      // end token and budget on one append: end token wins
      write_csr(REG_EOS_TOKEN, 32'd5);
      queue_req(make_req(CMD_SUBMIT, 16'd9, 16'd1, 16'd1, 0, 0));
      queue_req(make_req(CMD_APPEND, 16'd9, 0, 0, 32'd5, 0));
      wait_drained();
      // zero limits and a full scheduler, then limit raised under load
      write_csr(REG_MAX_ACTIVE, 32'd0);
      for (int i = 0; i < 3; i++)
         queue_req(make_req(CMD_SUBMIT, 16'(20 + i), 16'd1, 16'd3, 0, 0));
      queue_req(make_req(CMD_CANCEL, 16'd21, 0, 0, 0, 0));
      wait_drained();
      write_csr(REG_MAX_TOTAL, 32'd0);
      queue_req(make_req(CMD_SUBMIT, 16'd30, 16'd1, 16'd3, 0, 0));
      wait_drained();
      write_csr(REG_MAX_TOTAL, 32'h3F);
      write_csr(REG_MAX_ACTIVE, 32'hF);
      queue_req(make_req(CMD_NEXT, 16'd0, 0, 0, 0, 4'd1));
      wait_drained();

      // random phases across settings and idling mixes
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_csr(REG_MAX_ACTIVE, 32'd8); write_csr(REG_MAX_TOTAL, 32'd32); end
            1: begin write_csr(REG_MAX_ACTIVE, 32'd1); write_csr(REG_MAX_TOTAL, 32'd1); end
            2: begin write_csr(REG_MAX_ACTIVE, 32'd3); write_csr(REG_MAX_TOTAL, 32'd6); end
            3: begin write_csr(REG_MAX_ACTIVE, 32'hF); write_csr(REG_MAX_TOTAL, 32'd4); end
            4: begin write_csr(REG_MAX_ACTIVE, 32'd8); write_csr(REG_MAX_TOTAL, 32'h3F); end
            default: begin write_csr(REG_MAX_ACTIVE, 32'd5); write_csr(REG_MAX_TOTAL, 32'd20); end
         endcase
         write_csr(REG_EOS_TOKEN, (ph == 1) ? 32'h7FFF_FFFF : $urandom);
         sender_idle_pct = (ph == 1) ? 46 : (ph == 4 ? 11 : 0);
         stall_pct = (ph == 2 || ph == 3) ? 46 : (ph == 4 ? 11 : 0);
         for (int i = 0; i < 26; i++) begin
            // content depends on eos at queue time, which is fixed in a phase
            queue_req(random_req());
            if (i == 13) wait_drained();
         end
         wait_drained();
      end
      if (!failed && expected_rsps.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== request_batch_scheduler_core.f =====
sv/rbs_pkg.sv
sv/rbs_act_cell.sv
sv/rbs_wait_cell.sv
sv/request_batch_scheduler_core.sv
tb/testbench.sv
